[rtl/ils_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Indexed list store package
// Field widths, operation and status codes, and the command and status
// groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package ils_pkg;

  localparam int CAPACITY_DEF   = 64;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int OP_W     = 2;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 6;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;

  localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
  localparam logic [OP_W-1:0] OP_READ   = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic load;
    logic exec;
    logic app_write;
    logic rd_pos;
    logic rd_start;
    logic shift_step;
    logic dec_occ;
    logic res_load;
  } ils_cmd_t;

  typedef struct packed {
    logic op_append;
    logic op_read;
    logic op_remove;
    logic range_err;
    logic full;
    logic first_more;
    logic shift_more;
    logic out_free;
  } ils_stat_t;

endpackage
`default_nettype wire

[rtl/ils_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Indexed list store channels
// Request and response channels with valid/ready handshake and payload.
// ----------------------------------------------------------------------------
interface ils_req_if;
  import ils_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [OP_W-1:0]           operation;
  logic signed [VALUE_W-1:0] item_value;
  logic [POS_W-1:0]          position;

  modport source (output valid, output operation, output item_value, output position,
                  input ready);
  modport sink (input valid, input operation, input item_value, input position,
                output ready);
endinterface

interface ils_rsp_if;
  import ils_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] read_value;
  logic [STATUS_W-1:0]       status;
  logic [COUNT_W-1:0]        entry_count;

  modport source (output valid, output read_value, output status, output entry_count,
                  input ready);
  modport sink (input valid, input read_value, input status, input entry_count,
                output ready);
endinterface
`default_nettype wire

[rtl/indexed_list_store_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Indexed list store
// Ordered list of signed values in an entry memory with append, read and
// remove-at-index operations.
// ----------------------------------------------------------------------------
// Usage:
//   request carries operation, item_value and position; one beat asks for
//   one operation. response returns one beat per request with read_value,
//   status and entry_count (count after the operation).
//   Requests are taken one at a time: request.ready is high only while the
//   controller is idle.
//   A request beat is loaded and then executed; a remove with entries after
//   position then runs a shift loop that moves each later entry down one
//   place, one entry per cycle, through the single write and single read
//   port of the entry memory. Each result is then loaded into the
//   response register.
//   The response sits in an output register, so a new request is taken
//   while the previous response waits; if the receiver stalls, the block
//   holds the finished result in its last state until the register frees.
//   Reset empties the list and drops any pending response; memory contents
//   are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module indexed_list_store_top #(
  parameter int CAPACITY   = ils_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = ils_pkg::DATA_WIDTH_DEF
) (
  input wire logic clk,
  input wire logic rst,
  ils_req_if.sink   request,
  ils_rsp_if.source response
);
  import ils_pkg::*;

  ils_cmd_t  cmd;
  ils_stat_t stat;

  ils_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (request.valid),
    .req_ready (request.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ils_dpath #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .operation   (request.operation),
    .item_value  (request.item_value),
    .position    (request.position),
    .out_valid   (response.valid),
    .out_ready   (response.ready),
    .read_value  (response.read_value),
    .status      (response.status),
    .entry_count (response.entry_count)
  );

endmodule
`default_nettype wire

[rtl/ils_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Indexed list store controller
// Sequences one request: decode, at most a single memory access or a shift
// loop, then hand the result to the response register.
// ----------------------------------------------------------------------------
module ils_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              req_valid,
  output logic                   req_ready,
  input  wire ils_pkg::ils_stat_t stat,
  output ils_pkg::ils_cmd_t      cmd
);
  import ils_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EXEC  = 2'd1;
  localparam logic [1:0] S_SHIFT = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  assign req_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = S_DONE;
        if (stat.op_append && !stat.full) begin
          cmd.app_write = 1'b1;
        end else if (stat.op_read && !stat.range_err) begin
          cmd.rd_pos = 1'b1;
        end else if (stat.op_remove && !stat.range_err) begin
          if (stat.first_more) begin
            cmd.rd_start = 1'b1;
            state_next   = S_SHIFT;
          end else begin
            cmd.dec_occ = 1'b1;
          end
        end
      end
      S_SHIFT: begin
        cmd.shift_step = 1'b1;
        if (!stat.shift_more) begin
          cmd.dec_occ = 1'b1;
          state_next  = S_DONE;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

[rtl/ils_dpath.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Indexed list store datapath
// Entry memory, occupancy count, request registers, shift index and the
// response register.
// ----------------------------------------------------------------------------
module ils_dpath #(
  parameter int CAPACITY   = ils_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = ils_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire ils_pkg::ils_cmd_t                 cmd,
  output ils_pkg::ils_stat_t                     stat,
  input  wire logic [ils_pkg::OP_W-1:0]          operation,
  input  wire logic signed [ils_pkg::VALUE_W-1:0] item_value,
  input  wire logic [ils_pkg::POS_W-1:0]         position,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic signed [ils_pkg::VALUE_W-1:0]     read_value,
  output logic [ils_pkg::STATUS_W-1:0]           status,
  output logic [ils_pkg::COUNT_W-1:0]            entry_count
);
  import ils_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int OW = $clog2(CAPACITY + 1);
  localparam int CW = ((OW > POS_W) ? OW : POS_W) + 2;

  logic [DATA_WIDTH-1:0] mem [CAPACITY];
  logic [DATA_WIDTH-1:0] rd_q;

  logic [OP_W-1:0]       op_q;
  logic [DATA_WIDTH-1:0] value_q;
  logic [POS_W-1:0]      pos_q;
  logic [OW-1:0]         occ;
  logic [AW-1:0]         idx;
  logic [STATUS_W-1:0]   status_q;
  logic [STATUS_W-1:0]   status_next;

  logic                  we;
  logic [AW-1:0]         wa;
  logic [DATA_WIDTH-1:0] wd;
  logic                  re;
  logic [AW-1:0]         ra;

  always_comb begin
    stat.op_append  = (op_q == OP_APPEND);
    stat.op_read    = (op_q == OP_READ);
    stat.op_remove  = (op_q == OP_REMOVE);
    stat.range_err  = (CW'(pos_q) >= CW'(occ));
    stat.full       = (occ == OW'(CAPACITY));
    stat.first_more = ((CW'(pos_q) + CW'(1)) < CW'(occ));
    stat.shift_more = ((CW'(idx) + CW'(2)) < CW'(occ));
    stat.out_free   = !out_valid || out_ready;
  end

  always_comb begin
    if (stat.op_append && stat.full) begin
      status_next = ST_FULL;
    end else if ((stat.op_read || stat.op_remove) && stat.range_err) begin
      status_next = ST_RANGE;
    end else begin
      status_next = ST_OK;
    end
  end

  assign we = cmd.app_write || cmd.shift_step;
  assign wa = cmd.app_write ? AW'(occ) : idx;
  assign wd = cmd.app_write ? value_q : rd_q;
  assign re = cmd.rd_pos || cmd.rd_start || (cmd.shift_step && stat.shift_more);

  always_comb begin
    if (cmd.rd_pos) begin
      ra = AW'(pos_q);
    end else if (cmd.rd_start) begin
      ra = AW'(pos_q) + AW'(1);
    end else begin
      ra = idx + AW'(2);
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd_q <= mem[ra];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q    <= operation;
      value_q <= DATA_WIDTH'(item_value);
      pos_q   <= position;
    end
    if (cmd.exec) begin
      status_q <= status_next;
    end
    if (cmd.rd_start) begin
      idx <= AW'(pos_q);
    end else if (cmd.shift_step) begin
      idx <= idx + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else if (cmd.app_write) begin
      occ <= occ + OW'(1);
    end else if (cmd.dec_occ) begin
      occ <= occ - OW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      read_value  <= (stat.op_read && status_q == ST_OK) ?
                     signed'(VALUE_W'(rd_q)) : '0;
      status      <= status_q;
      entry_count <= COUNT_W'(occ);
    end
  end

endmodule
`default_nettype wire

[rtl/ils_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Indexed list store checker
// Port-level checks on the response channel and request pacing.
// ----------------------------------------------------------------------------
module ils_checker #(
  parameter int CAPACITY = ils_pkg::CAPACITY_DEF
) (
  input wire logic                               clk,
  input wire logic                               rst,
  input wire logic                               req_valid,
  input wire logic                               req_ready,
  input wire logic                               rsp_valid,
  input wire logic                               rsp_ready,
  input wire logic signed [ils_pkg::VALUE_W-1:0] read_value,
  input wire logic [ils_pkg::STATUS_W-1:0]       status,
  input wire logic [ils_pkg::COUNT_W-1:0]        entry_count
);
  import ils_pkg::*;

  localparam int CMP_W = 14;

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response beat dropped while stalled");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status != ST_OK |-> read_value == '0)
    else $error("read_value nonzero on error status");

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && CAPACITY < 128 |-> CMP_W'(entry_count) <= CMP_W'(CAPACITY))
    else $error("entry_count beyond capacity");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while previous one in progress");

endmodule

bind indexed_list_store_top ils_checker #(
  .CAPACITY (CAPACITY)
) u_ils_checker (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (request.valid),
  .req_ready   (request.ready),
  .rsp_valid   (response.valid),
  .rsp_ready   (response.ready),
  .read_value  (response.read_value),
  .status      (response.status),
  .entry_count (response.entry_count)
);
`default_nettype wire
